/* hdl/descending_sorted_insert_list_top_defines.svh */
// ----------------------------------------------------------------------------
// descending_sorted_insert_list_top_defines
// Assertion macros used by the sorted list datapath.
// ----------------------------------------------------------------------------
`ifndef DESCENDING_SORTED_INSERT_LIST_TOP_DEFINES_SVH
`define DESCENDING_SORTED_INSERT_LIST_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, idle in reset
`define DSIL_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define DSIL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/dsil_pkg.sv */
// ----------------------------------------------------------------------------
// dsil_pkg
// Types shared by the controller and datapath of the sorted list.
// ----------------------------------------------------------------------------
package dsil_pkg;

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_READ   = 2'd1,
		CMD_CLEAR  = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_READ,
		ST_FINISH
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic scan_step;
		logic read_cap;
		logic push;
	} ctrl_t;

	// datapath -> controller
	typedef struct packed {
		logic scan_last;
		logic out_free;
	} status_t;

endpackage

/* hdl/descending_sorted_insert_list_top.sv */
// Insert: the scan/shift walks the entry memory one position per cycle, through the
//   entries held and the slot just past them (only the stored entries when full).
// Read: registered memory read. Clear and unused code go straight to the result.
// One item in flight; the next is accepted once the result enters the output register.
// arst_n low empties the list; entry memory contents are not reset.
// ----------------------------------------------------------------------------
// descending_sorted_insert_list_top
// Bounded list of unsigned Q16.16 scores kept in descending order.
// ----------------------------------------------------------------------------
module descending_sorted_insert_list_top #(
	parameter int DEPTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // value[31:0], read_index[36:32], zero pad
	input  logic [1:0]  s_tuser,  // command[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata   // inserted_position[4:0], dropped[5], entry_value[37:6],
	                              // index_valid[38], entry_count[44:39], zero pad
);
	import dsil_pkg::*;

	ctrl_t   ctrl;
	status_t status;

	dsil_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_cmd   (s_tuser),
		.in_ready (s_tready),
		.status   (status),
		.ctrl     (ctrl)
	);

	dsil_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.status    (status),
		.in_cmd    (s_tuser),
		.in_value  (s_tdata[31:0]),
		.in_index  (s_tdata[36:32]),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata)
	);

endmodule

/* hdl/dsil_ctrl.sv */
// ----------------------------------------------------------------------------
// dsil_ctrl
// Sequencer: accept, walk the list (insert) or fetch an entry (read), then hand off result.
// ----------------------------------------------------------------------------
module dsil_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [1:0]        in_cmd,
	output logic              in_ready,
	input  dsil_pkg::status_t status,
	output dsil_pkg::ctrl_t   ctrl
);
	import dsil_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d        = state_q;
		ctrl           = '0;
		in_ready       = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctrl.load = 1'b1;
					unique case (cmd_t'(in_cmd))
						CMD_INSERT: state_d = ST_SCAN;
						CMD_READ:   state_d = ST_READ;
						default:    state_d = ST_FINISH;
					endcase
				end
			end
			ST_SCAN: begin
				ctrl.scan_step = 1'b1;
				if (status.scan_last) begin
					state_d = ST_FINISH;
				end
			end
			ST_READ: begin
				ctrl.read_cap = 1'b1;
				state_d       = ST_FINISH;
			end
			ST_FINISH: begin
				if (status.out_free) begin
					ctrl.push = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

/* hdl/dsil_dp.sv */
// ----------------------------------------------------------------------------
// dsil_dp
// Entry memory, count, scan/shift step and the output register.
// ----------------------------------------------------------------------------
`include "descending_sorted_insert_list_top_defines.svh"

module dsil_dp #(
	parameter int DEPTH = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  dsil_pkg::ctrl_t   ctrl,
	output dsil_pkg::status_t status,
	input  logic [1:0]        in_cmd,
	input  logic [31:0]       in_value,
	input  logic [4:0]        in_index,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [47:0]       out_data
);
	import dsil_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [31:0]   mem [DEPTH];
	logic [31:0]   rd_data_q;
	logic [AW-1:0] rd_addr;
	logic          we;
	logic [AW-1:0] waddr;
	logic [31:0]   wdata;

	logic [31:0]   val_q;
	logic [4:0]    idx_q;
	logic [AW-1:0] i_q;
	logic          found_q;
	logic [31:0]   carry_q;
	logic [AW-1:0] pos_q;
	logic [CW-1:0] count_q;

	logic [AW-1:0] res_pos_q;
	logic          res_drop_q;
	logic [31:0]   res_entry_q;
	logic          res_valid_q;

	logic [31:0]   idx_ext;
	logic [31:0]   pos_ext;
	logic [31:0]   count_ext;
	logic [AW-1:0] last_idx;
	logic          virt;
	logic          hit;
	logic          rd_ok;

	assign idx_ext  = 32'(in_index);
	assign last_idx = (count_q < CW'(DEPTH)) ? count_q[AW-1:0] : AW'(DEPTH - 1);
	// the slot just past the stored entries always hits, so a value not yet placed lands there
	assign virt     = (CW'(i_q) == count_q);
	assign hit      = virt || (val_q >= rd_data_q);
	assign rd_ok    = (32'(idx_q) < 32'(count_q));

	assign status.scan_last = (i_q == last_idx);
	assign status.out_free  = !out_valid || out_ready;

	always_comb begin
		if (ctrl.load) begin
			rd_addr = (cmd_t'(in_cmd) == CMD_INSERT) ? '0 : idx_ext[AW-1:0];
		end else begin
			rd_addr = i_q + AW'(1);
		end
	end

	// ripple the new value in: once placed, each step writes the carried entry
	always_comb begin
		we    = 1'b0;
		waddr = i_q;
		wdata = carry_q;
		if (ctrl.scan_step) begin
			if (!found_q && hit) begin
				we    = 1'b1;
				wdata = val_q;
			end else if (found_q) begin
				we = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			val_q       <= in_value;
			idx_q       <= in_index;
			i_q         <= '0;
			found_q     <= 1'b0;
			res_pos_q   <= '0;
			res_drop_q  <= 1'b0;
			res_entry_q <= '0;
			res_valid_q <= 1'b0;
		end
		if (ctrl.scan_step) begin
			i_q <= i_q + AW'(1);
			if (!found_q && hit) begin
				found_q <= 1'b1;
				pos_q   <= i_q;
				carry_q <= rd_data_q;
			end else if (found_q) begin
				carry_q <= rd_data_q;
			end
			if (status.scan_last) begin
				res_pos_q  <= found_q ? pos_q : (hit ? i_q : '0);
				res_drop_q <= !(found_q || hit);
			end
		end
		if (ctrl.read_cap) begin
			res_entry_q <= rd_ok ? rd_data_q : '0;
			res_valid_q <= rd_ok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctrl.load && cmd_t'(in_cmd) == CMD_CLEAR) begin
			count_q <= '0;
		end else if (ctrl.scan_step && status.scan_last && count_q < CW'(DEPTH)) begin
			count_q <= count_q + CW'(1);
		end
	end

	assign pos_ext   = 32'(res_pos_q);
	assign count_ext = 32'(count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (ctrl.push) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			out_data <= {3'b000, count_ext[5:0], res_valid_q, res_entry_q,
				res_drop_q, pos_ext[4:0]};
		end
	end

	`DSIL_ASSERT_NOW(a_count_bound, 1'b1, 32'(count_q) <= DEPTH, "entry count above depth")
	`DSIL_ASSERT_NOW(a_scan_bound, ctrl.scan_step, i_q <= last_idx, "scan ran past list end")
	`DSIL_ASSERT_NOW(a_drop_pos, ctrl.push && res_drop_q, res_pos_q == '0 && !res_valid_q,
		"dropped insert carries position or read flag")
	`DSIL_ASSERT_NEXT(a_drop_full, ctrl.scan_step && status.scan_last && !(found_q || hit),
		32'(count_q) == DEPTH, "drop while list not full")

endmodule

/* sim/sorted_list_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_list_checker
// Watches both streams of the sorted list, keeps its own copy of the list,
// predicts the result of every accepted command and compares it field by
// field with the result transfers, in order.
// ----------------------------------------------------------------------------
module sorted_list_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [39:0] s_tdata,  // value[31:0], read_index[36:32], zero pad
	input  logic [1:0]  s_tuser,  // command[1:0]
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [47:0] m_tdata,  // inserted_position[4:0], dropped[5], entry_value[37:6],
	                              // index_valid[38], entry_count[44:39], zero pad
	output int          fail_count,
	output int          results_owed
);
	import dsil_pkg::*;

	localparam int LIST_DEPTH = 32;

	typedef struct packed {
		logic [4:0]  position;
		logic        dropped;
		logic [31:0] entry;
		logic        index_valid;
		logic [5:0]  count;
	} list_result_t;

	logic [31:0]  score_list [LIST_DEPTH];
	int           list_len;
	list_result_t expected_results [$];

	initial begin
		fail_count   = 0;
		results_owed = 0;
		list_len     = 0;
	end

	// applies one command to the shadow list and returns what the block should answer
	function automatic list_result_t apply_list_command(logic [1:0] code, logic [31:0] score,
		logic [4:0] idx);
		list_result_t r;
		int           pos;
		int           i;
		bit           found;
		r = '0;
		case (cmd_t'(code))
			CMD_INSERT: begin
				pos   = list_len;
				found = 1'b0;
				// new score goes ahead of the first entry not greater than it
				for (i = 0; i < list_len; i++) begin
					if (!found && score >= score_list[i]) begin
						pos   = i;
						found = 1'b1;
					end
				end
				if (list_len == LIST_DEPTH && pos == list_len) begin
					r.dropped = 1'b1;
				end else begin
					for (i = (list_len < LIST_DEPTH) ? list_len : LIST_DEPTH - 1; i > pos; i--)
						score_list[i] = score_list[i - 1];
					score_list[pos] = score;
					if (list_len < LIST_DEPTH)
						list_len++;
					r.position = pos[4:0];
				end
			end
			CMD_READ: begin
				if (int'(idx) < list_len) begin
					r.entry       = score_list[idx];
					r.index_valid = 1'b1;
				end
			end
			CMD_CLEAR: begin
				list_len = 0;
			end
			default: begin
			end
		endcase
		r.count = list_len[5:0];
		return r;
	endfunction

	task automatic report_mismatch(string msg);
		$display("MISMATCH at %0t: %s", $time, msg);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		list_result_t got;
		list_result_t want;
		if (!arst_n) begin
			list_len = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.position    = m_tdata[4:0];
				got.dropped     = m_tdata[5];
				got.entry       = m_tdata[37:6];
				got.index_valid = m_tdata[38];
				got.count       = m_tdata[44:39];
				if (expected_results.size() == 0) begin
					report_mismatch("result transfer with nothing pending");
				end else begin
					want = expected_results.pop_front();
					if (got.position !== want.position)
						report_mismatch($sformatf("inserted_position got %0d, want %0d",
							got.position, want.position));
					if (got.dropped !== want.dropped)
						report_mismatch($sformatf("dropped got %0b, want %0b",
							got.dropped, want.dropped));
					if (got.entry !== want.entry)
						report_mismatch($sformatf("entry_value got 0x%08h, want 0x%08h",
							got.entry, want.entry));
					if (got.index_valid !== want.index_valid)
						report_mismatch($sformatf("index_valid got %0b, want %0b",
							got.index_valid, want.index_valid));
					if (got.count !== want.count)
						report_mismatch($sformatf("entry_count got %0d, want %0d",
							got.count, want.count));
				end
			end
			if (s_tvalid && s_tready)
				expected_results.push_back(apply_list_command(s_tuser, s_tdata[31:0],
					s_tdata[36:32]));
			results_owed <= expected_results.size();
		end
	end

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the descending sorted list: a directed opening on empty,
// equal and extreme scores, then random runs of inserts and reads that fill
// the list past its depth, with clears and unused codes mixed in. Both
// streams stall in random bursts; the checker beside the block does the
// prediction and comparison.
// ----------------------------------------------------------------------------
module tb_top;
	import dsil_pkg::*;

	localparam logic [1:0] CMD_UNUSED   = 2'd3;
	localparam int         RANDOM_ITEMS = 1750;
	localparam int         CALM_TAIL    = 150;
	localparam int         QUIET_LIMIT  = 2000;
	localparam int         DRAIN_CYCLES = 48;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;

	int          fail_count;
	int          results_owed;
	int          quiet_cycles;
	int          items_sent;
	int          run_len;
	int          roll;
	bit          calm;
	logic [31:0] last_score;

	descending_sorted_insert_list_top #(
		.DEPTH(32)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	sorted_list_checker u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tuser      (s_tuser),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.fail_count   (fail_count),
		.results_owed (results_owed)
	);

	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// called right after a rising edge; returns at the edge of the transfer
	task automatic send_item(input logic [1:0] code, input logic [31:0] score,
		input logic [4:0] idx);
		if (!calm && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= code;
		s_tdata  <= {3'b000, idx, score};
		do @(posedge clk); while (!s_tready);
		items_sent++;
		if (code == CMD_INSERT)
			last_score = score;
	endtask

	// extremes, small whole values, repeats of the last score (equal case) and one-bit flips of it
	function automatic logic [31:0] pick_score();
		case ($urandom_range(0, 9))
			0:       return 32'h0000_0000;
			1:       return 32'hFFFF_FFFF;
			2, 3:    return 32'($urandom_range(0, 7)) << 16;
			4:       return last_score;
			5:       return last_score ^ (32'h1 << $urandom_range(0, 31));
			default: return $urandom;
		endcase
	endfunction

	// result side: ready drops in bursts, none in the calm tail
	initial begin
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (!calm && $urandom_range(0, 2) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 9)) @(posedge clk);
			end
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
				$display("** descending_sorted_insert_list_top: FAILED **");
				$finish;
			end
		end
	end

	initial begin
		arst_n     = 1'b0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		s_tuser    = '0;
		calm       = 1'b0;
		items_sent = 0;
		last_score = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// empty list, extremes, equal scores, reads past the count, unused code
		send_item(CMD_READ,   32'hFFFF_FFFF, 5'd0);
		send_item(CMD_READ,   32'h0000_0000, 5'd31);
		send_item(CMD_INSERT, 32'h0000_0000, 5'd31);
		send_item(CMD_INSERT, 32'hFFFF_FFFF, 5'd0);
		send_item(CMD_INSERT, 32'h8000_0000, 5'd0);
		send_item(CMD_INSERT, 32'h8000_0000, 5'd0);
		send_item(CMD_INSERT, 32'h0000_0000, 5'd0);
		for (int i = 0; i < 5; i++)
			send_item(CMD_READ, 32'h0000_0000, 5'(i));
		send_item(CMD_READ,   32'h0000_0000, 5'd5);
		send_item(CMD_READ,   32'hFFFF_FFFF, 5'd31);
		send_item(CMD_UNUSED, 32'hFFFF_FFFF, 5'd31);
		send_item(CMD_READ,   32'h0000_0000, 5'd4);
		send_item(CMD_CLEAR,  32'hFFFF_FFFF, 5'd31);
		send_item(CMD_READ,   32'h0000_0000, 5'd0);
		send_item(CMD_INSERT, 32'h0001_0000, 5'd0);
		send_item(CMD_READ,   32'h0000_0000, 5'd0);

		// random runs, long enough that many overflow the list
		while (items_sent < RANDOM_ITEMS) begin
			calm = (items_sent >= RANDOM_ITEMS - CALM_TAIL);
			if ($urandom_range(0, 9) < 7)
				send_item(CMD_CLEAR, $urandom, 5'($urandom_range(0, 31)));
			run_len = $urandom_range(4, 70);
			repeat (run_len) begin
				roll = $urandom_range(0, 99);
				if (roll < 62)
					send_item(CMD_INSERT, pick_score(), 5'($urandom_range(0, 31)));
				else if (roll < 94)
					send_item(CMD_READ, $urandom, 5'($urandom_range(0, 31)));
				else if (roll < 97)
					send_item(CMD_UNUSED, $urandom, 5'($urandom_range(0, 31)));
				else
					send_item(CMD_CLEAR, $urandom, 5'($urandom_range(0, 31)));
				calm = (items_sent >= RANDOM_ITEMS - CALM_TAIL);
			end
		end
		s_tvalid <= 1'b0;

		do @(posedge clk); while (results_owed != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0 && results_owed == 0)
			$display("** descending_sorted_insert_list_top: PASSED **");
		else
			$display("** descending_sorted_insert_list_top: FAILED **");
		$finish;
	end

endmodule

/* descending_sorted_insert_list_top.f */
+incdir+hdl
hdl/dsil_pkg.sv
hdl/dsil_ctrl.sv
hdl/dsil_dp.sv
hdl/descending_sorted_insert_list_top.sv
sim/sorted_list_checker.sv
sim/tb_top.sv
